@@ sv/loseg_pkg.sv @@
`timescale 1ns / 1ps

package loseg_pkg;

    localparam int COORD_BITS     = 11;
    localparam int SIZE_BITS      = 11;
    localparam int ACTIVE_BITS    = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_LABEL_BITS = 16;

    localparam logic [ACTIVE_BITS-1:0] RST_ACTIVE_LABEL = 16'd1;
    localparam logic [SIZE_BITS-1:0]   RST_IMAGE_WIDTH  = 11'd512;
    localparam logic [SIZE_BITS-1:0]   RST_IMAGE_HEIGHT = 11'd512;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ACTIVE_LABEL = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [ACTIVE_BITS-1:0] active_label;
        logic [SIZE_BITS-1:0]   image_width;
        logic [SIZE_BITS-1:0]   image_height;
    } cfg_t;

    // Segment mask bits in emission order: upper, lower, left, right side.
    typedef struct packed {
        logic [3:0] mask;
        coord_t     x0;
        coord_t     y0;
        coord_t     x1;
        coord_t     y1;
    } job_t;

endpackage

@@ sv/loseg_if.sv @@
`timescale 1ns / 1ps

interface pixel_if #(
    parameter int LABEL_BITS = loseg_pkg::DEF_LABEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic [LABEL_BITS-1:0] pixel_label;
    logic                  frame_start;

    modport source (output valid, output pixel_label, output frame_start, input ready);
    modport sink (input valid, input pixel_label, input frame_start, output ready);
endinterface

interface segment_if;
    import loseg_pkg::*;

    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   last_of_pixel;

    modport source (
        output valid, output start_x, output start_y, output end_x, output end_y,
        output last_of_pixel, input ready
    );
    modport sink (
        input valid, input start_x, input start_y, input end_x, input end_y,
        input last_of_pixel, output ready
    );
endinterface

@@ sv/loseg_ram.sv @@
`timescale 1ns / 1ps

module loseg_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the entry being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/loseg_front.sv @@
`timescale 1ns / 1ps

module loseg_front #(
    parameter int MAX_WIDTH  = loseg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = loseg_pkg::DEF_MAX_HEIGHT,
    parameter int LABEL_BITS = loseg_pkg::DEF_LABEL_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  loseg_pkg::cfg_t cfg,
    pixel_if.sink           pixel,
    output logic            job_valid,
    input  logic            job_ready,
    output loseg_pkg::job_t job
);
    import loseg_pkg::*;

    localparam int XB = $clog2(MAX_WIDTH);
    localparam int YB = $clog2(MAX_HEIGHT);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);

    logic [XB-1:0] col_reg, col_next;
    logic [YB-1:0] row_reg, row_next;
    logic          left_reg, left_next;
    logic [WB-1:0] fill_reg, fill_next;

    logic          s1_valid_reg, s1_valid_next;
    logic [XB-1:0] s1_x_reg;
    logic [YB-1:0] s1_y_reg;
    logic          s1_m_reg;
    logic          s1_top_reg;
    logic          s1_known_reg;
    logic [3:1]    s1_side_reg;

    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic          accept;
    logic          s1_go;
    logic [XB-1:0] x_cur;
    logic [YB-1:0] y_cur;
    logic [31:0]   x_inc;
    logic [31:0]   y_inc;
    logic          match;
    logic          known;
    logic [3:1]    side;
    logic          rd_bit;
    logic          upper;
    logic [3:0]    mask;

    always_comb
    begin
        if (cfg.image_width == '0)
        begin
            w_eff = WB'(1);
        end
        else if (32'(cfg.image_width) > 32'(MAX_WIDTH))
        begin
            w_eff = WB'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WB'(cfg.image_width);
        end

        if (cfg.image_height == '0)
        begin
            h_eff = HB'(1);
        end
        else if (32'(cfg.image_height) > 32'(MAX_HEIGHT))
        begin
            h_eff = HB'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HB'(cfg.image_height);
        end
    end

    assign accept      = pixel.valid && pixel.ready;
    assign pixel.ready = !s1_valid_reg || s1_go;

    assign x_cur = pixel.frame_start ? '0 : col_reg;
    assign y_cur = pixel.frame_start ? '0 : row_reg;
    assign x_inc = 32'(x_cur) + 32'd1;
    assign y_inc = 32'(y_cur) + 32'd1;
    assign match = pixel.pixel_label == LABEL_BITS'(cfg.active_label);

    // Entries at or beyond the fill count were never written since reset.
    assign known = 32'(x_cur) < 32'(fill_reg);

    assign side[1] = match && (y_inc == 32'(h_eff));
    assign side[2] = (x_cur == '0) ? match : (match != left_reg);
    assign side[3] = match && (x_inc == 32'(w_eff));

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            left_next = match;
            if (x_inc > 32'(fill_reg))
            begin
                fill_next = WB'(x_inc);
            end
            if (x_inc >= 32'(w_eff))
            begin
                col_next = '0;
                row_next = (y_inc >= 32'(h_eff)) ? '0 : YB'(y_inc);
            end
            else
            begin
                col_next = XB'(x_inc);
                row_next = y_cur;
            end
        end
    end

    loseg_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (accept),
        .waddr (x_cur),
        .wdata (match),
        .re    (accept),
        .raddr (x_cur),
        .rdata (rd_bit)
    );

    assign upper = s1_top_reg ? s1_m_reg : (s1_m_reg != (s1_known_reg && rd_bit));
    assign mask  = {s1_side_reg, upper};

    assign s1_go     = s1_valid_reg && ((mask == '0) || job_ready);
    assign job_valid = s1_valid_reg && (mask != '0);

    always_comb
    begin
        job.mask = mask;
        job.x0   = COORD_BITS'(s1_x_reg);
        job.y0   = COORD_BITS'(s1_y_reg);
        job.x1   = COORD_BITS'(32'(s1_x_reg) + 32'd1);
        job.y1   = COORD_BITS'(32'(s1_y_reg) + 32'd1);
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= 1'b0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            left_reg     <= left_next;
            fill_reg     <= fill_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg     <= x_cur;
            s1_y_reg     <= y_cur;
            s1_m_reg     <= match;
            s1_top_reg   <= (y_cur == '0);
            s1_known_reg <= known;
            s1_side_reg  <= side;
        end
    end

endmodule

@@ sv/loseg_emit.sv @@
`timescale 1ns / 1ps

module loseg_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_ready,
    input  loseg_pkg::job_t job,
    segment_if.source       segment
);
    import loseg_pkg::*;

    logic       e_valid_reg, e_valid_next;
    logic [3:0] e_mask_reg, e_mask_next;
    coord_t     e_x0_reg, e_y0_reg, e_x1_reg, e_y1_reg;

    logic       last;
    logic       out_take;
    logic       load;

    assign last      = (e_mask_reg & (e_mask_reg - 4'd1)) == '0;
    assign out_take  = segment.valid && segment.ready;
    assign job_ready = !e_valid_reg || (last && segment.ready);
    assign load      = job_valid && job_ready;

    assign segment.valid         = e_valid_reg;
    assign segment.last_of_pixel = last;

    always_comb
    begin
        if (e_mask_reg[0])
        begin
            segment.start_x = e_x0_reg;
            segment.start_y = e_y0_reg;
            segment.end_x   = e_x1_reg;
            segment.end_y   = e_y0_reg;
        end
        else if (e_mask_reg[1])
        begin
            segment.start_x = e_x0_reg;
            segment.start_y = e_y1_reg;
            segment.end_x   = e_x1_reg;
            segment.end_y   = e_y1_reg;
        end
        else if (e_mask_reg[2])
        begin
            segment.start_x = e_x0_reg;
            segment.start_y = e_y0_reg;
            segment.end_x   = e_x0_reg;
            segment.end_y   = e_y1_reg;
        end
        else
        begin
            segment.start_x = e_x1_reg;
            segment.start_y = e_y0_reg;
            segment.end_x   = e_x1_reg;
            segment.end_y   = e_y1_reg;
        end
    end

    always_comb
    begin
        e_valid_next = e_valid_reg;
        e_mask_next  = e_mask_reg;
        if (load)
        begin
            e_valid_next = 1'b1;
            e_mask_next  = job.mask;
        end
        else if (out_take)
        begin
            e_mask_next = e_mask_reg & (e_mask_reg - 4'd1);
            if (last)
            begin
                e_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            e_mask_reg  <= '0;
        end
        else
        begin
            e_valid_reg <= e_valid_next;
            e_mask_reg  <= e_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            e_x0_reg <= job.x0;
            e_y0_reg <= job.y0;
            e_x1_reg <= job.x1;
            e_y1_reg <= job.y1;
        end
    end

endmodule

@@ sv/label_outline_segment_extractor.sv @@
`timescale 1ns / 1ps
// A taken pixel is registered in the front stage, then loaded into the emitter, which offers its
// first segment; a busy emitter holds it back. Throughput: the single segment port moves one segment
// per cycle when ready, one to four per pixel; other pixels flow at one per cycle unless held.
// Reset: registers return to active label 1 and a 512 by 512 slice, and position counters clear.
// The row store is not cleared; a fill count marks the columns written since reset.

module label_outline_segment_extractor #(
    parameter int MAX_WIDTH  = loseg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = loseg_pkg::DEF_MAX_HEIGHT,
    parameter int LABEL_BITS = loseg_pkg::DEF_LABEL_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [loseg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [loseg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    pixel_if.sink                                pixel,
    segment_if.source                            segment
);
    import loseg_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic job_valid;
    logic job_ready;
    job_t job;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ACTIVE_LABEL: cfg_next.active_label = ACTIVE_BITS'(cfg_data);
                REG_IMAGE_WIDTH:  cfg_next.image_width  = SIZE_BITS'(cfg_data);
                REG_IMAGE_HEIGHT: cfg_next.image_height = SIZE_BITS'(cfg_data);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_label <= RST_ACTIVE_LABEL;
            cfg_reg.image_width  <= RST_IMAGE_WIDTH;
            cfg_reg.image_height <= RST_IMAGE_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    loseg_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .LABEL_BITS (LABEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pixel     (pixel),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    loseg_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .segment   (segment)
    );

endmodule

@@ test/label_outline_segment_extractor_test.sv @@
`timescale 1ns / 1ps

module label_outline_segment_extractor_test;
    import loseg_pkg::*;

    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam int MAX_H = DEF_MAX_HEIGHT;
    localparam int LABEL_W = DEF_LABEL_BITS;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [LABEL_W-1:0] label;
        logic               frame_start;
    } pixel_req_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        logic   last_of_pixel;
    } segment_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    pixel_if #(.LABEL_BITS(LABEL_W)) pixel_ch ();
    segment_if segment_ch ();

    label_outline_segment_extractor #(
        .MAX_WIDTH(MAX_W),
        .MAX_HEIGHT(MAX_H),
        .LABEL_BITS(LABEL_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel(pixel_ch),
        .segment(segment_ch)
    );

    pixel_req_t pending_pixels[$];
    segment_t expected_segments[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    cfg_t settings;
    logic [MAX_W-1:0] row_flags;
    logic left_flag;
    int unsigned col_pos;
    int unsigned row_pos;

    always #5 clk = ~clk;

    function automatic int unsigned clamp_size(input logic [SIZE_BITS-1:0] v, input int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic segment_t make_seg(input int unsigned sx, input int unsigned sy,
                                          input int unsigned ex, input int unsigned ey);
        segment_t s;
        s.start_x = coord_t'(sx);
        s.start_y = coord_t'(sy);
        s.end_x = coord_t'(ex);
        s.end_y = coord_t'(ey);
        s.last_of_pixel = 1'b0;
        return s;
    endfunction

    function automatic void predict_outline(input logic [LABEL_W-1:0] label, input logic fs);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        logic m;
        logic up;
        segment_t segs[$];
        w = clamp_size(settings.image_width, MAX_W);
        h = clamp_size(settings.image_height, MAX_H);
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        x = col_pos;
        y = row_pos;
        if (x >= MAX_W)
            x = 0;
        m = (label == settings.active_label[LABEL_W-1:0]);
        up = row_flags[x];
        if (y == 0 ? m : (m != up))
            segs.push_back(make_seg(x, y, x + 1, y));
        if (m && y == h - 1)
            segs.push_back(make_seg(x, y + 1, x + 1, y + 1));
        if (x == 0 ? m : (m != left_flag))
            segs.push_back(make_seg(x, y, x, y + 1));
        if (m && x == w - 1)
            segs.push_back(make_seg(x + 1, y, x + 1, y + 1));
        if (segs.size() > 0)
            segs[segs.size() - 1].last_of_pixel = 1'b1;
        foreach (segs[i])
            expected_segments.push_back(segs[i]);
        row_flags[x] = m;
        left_flag = m;
        if (x + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end
        else
        begin
            col_pos = x + 1;
            row_pos = y;
        end
    endfunction

    function automatic void note_mismatch(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, what);
    endfunction

    function automatic string seg_text(input segment_t s);
        return $sformatf("(%0d,%0d)-(%0d,%0d) last=%0b",
                         s.start_x, s.start_y, s.end_x, s.end_y, s.last_of_pixel);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_req_t req;
        if (!rst_n)
        begin
            pixel_ch.valid <= 1'b0;
            pixel_ch.pixel_label <= '0;
            pixel_ch.frame_start <= 1'b0;
        end
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
                predict_outline(pixel_ch.pixel_label, pixel_ch.frame_start);
            if (!pixel_ch.valid || pixel_ch.ready)
            begin
                if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req = pending_pixels.pop_front();
                    pixel_ch.valid <= 1'b1;
                    pixel_ch.pixel_label <= req.label;
                    pixel_ch.frame_start <= req.frame_start;
                end
                else
                begin
                    pixel_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        segment_t got;
        segment_t want;
        if (!rst_n)
        begin
            segment_ch.ready <= 1'b0;
        end
        else
        begin
            if (segment_ch.valid && segment_ch.ready)
            begin
                got.start_x = segment_ch.start_x;
                got.start_y = segment_ch.start_y;
                got.end_x = segment_ch.end_x;
                got.end_y = segment_ch.end_y;
                got.last_of_pixel = segment_ch.last_of_pixel;
                if (expected_segments.size() == 0)
                begin
                    note_mismatch({"unexpected segment ", seg_text(got)});
                end
                else
                begin
                    want = expected_segments.pop_front();
                    if (got !== want)
                        note_mismatch({"segment mismatch: expected ", seg_text(want),
                                       ", got ", seg_text(got)});
                end
            end
            segment_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_pixel(input logic [LABEL_W-1:0] label, input logic fs);
        pixel_req_t req;
        req.label = label;
        req.frame_start = fs;
        pending_pixels.push_back(req);
    endtask

    task automatic drain();
        int quiet;
        quiet = 0;
        while (quiet < SETTLE_CYCLES)
        begin
            @(posedge clk);
            if (pending_pixels.size() != 0 || pixel_ch.valid || expected_segments.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_ACTIVE_LABEL: settings.active_label = data[ACTIVE_BITS-1:0];
            REG_IMAGE_WIDTH:  settings.image_width = data[SIZE_BITS-1:0];
            REG_IMAGE_HEIGHT: settings.image_height = data[SIZE_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [CFG_DATA_BITS-1:0] label,
                            input logic [CFG_DATA_BITS-1:0] w,
                            input logic [CFG_DATA_BITS-1:0] h);
        write_reg(REG_ACTIVE_LABEL, label);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [LABEL_W-1:0] pick_label(input logic [LABEL_W-1:0] act);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return act;
            6, 7: return act ^ (LABEL_W'(1) << $urandom_range(LABEL_W - 1));
            default: return LABEL_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_size();
        case ($urandom_range(11))
            0: return CFG_DATA_BITS'($urandom);
            1: return CFG_DATA_BITS'($urandom_range(2047));
            2: return '0;
            default: return CFG_DATA_BITS'($urandom_range(1, 6));
        endcase
    endfunction

    initial
    begin
        int idle_plan[4][2];
        logic [LABEL_W-1:0] act;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ACTIVE_LABEL;
        cfg_data = '0;
        pixel_ch.valid = 1'b0;
        pixel_ch.pixel_label = '0;
        pixel_ch.frame_start = 1'b0;
        segment_ch.ready = 1'b0;
        settings.active_label = RST_ACTIVE_LABEL;
        settings.image_width = RST_IMAGE_WIDTH;
        settings.image_height = RST_IMAGE_HEIGHT;
        row_flags = '0;
        left_flag = 1'b0;
        col_pos = 0;
        row_pos = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_regs(16'd5, 16'd3, 16'd2);
        push_pixel(16'd5, 1'b1);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'd5, 1'b0);
        push_pixel(16'd5, 1'b0);
        push_pixel(16'd5, 1'b0);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'd5, 1'b0);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'd5, 1'b0);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'd5, 1'b0);
        push_pixel(16'd5, 1'b0);
        push_pixel(16'd0, 1'b1);
        drain();
        set_regs(16'hFFFF, 16'd1, 16'd1);
        push_pixel(16'hFFFF, 1'b1);
        push_pixel(16'd0, 1'b0);
        push_pixel(16'hFFFF, 1'b0);
        drain();
        set_regs(16'd0, 16'd0, 16'd0);
        push_pixel(16'd0, 1'b1);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'd0, 1'b0);
        drain();
        set_regs(16'd7, 16'd4, 16'd3);
        push_pixel(16'd7, 1'b1);
        push_pixel(16'd7, 1'b0);
        push_pixel(16'd7, 1'b0);
        drain();
        set_regs(16'd9, 16'd2, 16'd3);
        push_pixel(16'd9, 1'b0);
        push_pixel(16'd7, 1'b0);
        push_pixel(16'd9, 1'b0);
        drain();

        set_regs(16'd1, 16'hFFFF, 16'd1);
        push_pixel(pick_label(16'd1), 1'b1);
        repeat (15) push_pixel(pick_label(16'd1), 1'b0);
        drain();
        set_regs(16'd1, 16'd1, 16'd2047);
        push_pixel(pick_label(16'd1), 1'b1);
        repeat (15) push_pixel(pick_label(16'd1), 1'b0);
        drain();

        idle_plan = '{'{0, 0}, '{85, 0}, '{0, 85}, '{30, 30}};
        foreach (idle_plan[p])
        begin
            send_idle_pct = idle_plan[p][0];
            recv_stall_pct = idle_plan[p][1];
            repeat (2)
            begin
                act = LABEL_W'($urandom);
                set_regs(act, pick_size(), pick_size());
                push_pixel(pick_label(act), 1'($urandom_range(1)));
                repeat (7) push_pixel(pick_label(act), ($urandom_range(19) == 0));
                drain();
            end
        end

        if (expected_segments.size() != 0)
            note_mismatch($sformatf("%0d segments never arrived", expected_segments.size()));
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
